@@ src/frame_reassembly_slot_tracker_assert.svh @@
// Assertion macros used by the checker file of the frame reassembly slot tracker.
// Depends on nothing. Each macro expects clk and rst_n to be visible where it is used.
`ifndef FRAME_REASSEMBLY_SLOT_TRACKER_ASSERT_SVH
`define FRAME_REASSEMBLY_SLOT_TRACKER_ASSERT_SVH

// A consequent that must hold in the same cycle as its antecedent.
`define FRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/frs_pkg.sv @@
// Shared types, constants and helper functions of the frame reassembly slot tracker.
// Depends on nothing; the design and checker files of the block refer to it by scoped names.
`default_nettype none

package frs_pkg;

    localparam int SLOTS       = 5;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int FRAME_W     = 32;
    localparam int LINE_W      = 16;
    localparam int SLOT_OUT_W  = 3;
    localparam int DIGIT_W     = 8;
    localparam int NUM_DIGITS  = FRAME_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic [LINE_W-1:0]  line_index;
        logic [LINE_W-1:0]  frame_height;
    } frs_in_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] write_slot;
        logic [LINE_W-1:0]     write_line;
        logic                  opened_slot;
        logic                  overwrote_frame;
        logic                  emit_valid;
        logic [SLOT_OUT_W-1:0] emit_slot;
        logic [FRAME_W-1:0]    emit_frame;
        logic                  emit_gap;
        logic                  drop_valid;
        logic [SLOT_OUT_W-1:0] drop_slot;
        logic [FRAME_W-1:0]    drop_frame;
    } frs_out_t;

    // A classified header: the input fields plus the slot its frame maps to.
    typedef struct packed {
        frs_in_t   hdr;
        slot_idx_t slot;
    } frs_job_t;

    // Slot of frame n-k given the slot of frame n, for k of one to three.
    function automatic slot_idx_t slot_back(slot_idx_t s, logic [1:0] k);
        logic [SLOT_W:0] wide;
        wide = {1'b0, s} + (SLOT_W+1)'(SLOTS) - (SLOT_W+1)'(k);
        if (wide >= (SLOT_W+1)'(SLOTS))
        begin
            wide = wide - (SLOT_W+1)'(SLOTS);
        end
        return SLOT_W'(wide);
    endfunction

endpackage

`default_nettype wire

@@ src/frs_front.sv @@
// Front part: accepts line headers and works out frame_number modulo SLOTS one byte a cycle.
// Depends on frs_pkg.
`default_nettype none

module frs_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire frs_pkg::frs_in_t in_data,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output frs_pkg::frs_job_t     job
);

    // Folds one byte into a running remainder, most significant bit first.
    function automatic frs_pkg::slot_idx_t mod_digit(frs_pkg::slot_idx_t r,
                                                     logic [frs_pkg::DIGIT_W-1:0] d);
        logic [frs_pkg::SLOT_W:0] acc;
        acc = {1'b0, r};
        for (int i = 0; i < frs_pkg::DIGIT_W; i++)
        begin
            acc = {acc[frs_pkg::SLOT_W-1:0], d[frs_pkg::DIGIT_W-1-i]};
            if (acc >= (frs_pkg::SLOT_W+1)'(frs_pkg::SLOTS))
            begin
                acc = acc - (frs_pkg::SLOT_W+1)'(frs_pkg::SLOTS);
            end
        end
        return frs_pkg::SLOT_W'(acc);
    endfunction

    logic                             busy_reg,  busy_next;
    logic [frs_pkg::DIGIT_CNT_W-1:0]  digit_reg, digit_next;
    frs_pkg::slot_idx_t               rem_reg,   rem_next;
    logic [frs_pkg::FRAME_W-1:0]      shift_reg, shift_next;
    frs_pkg::frs_in_t                 hdr_reg,   hdr_next;

    frs_pkg::slot_idx_t rem_step;
    logic               last_digit;
    logic               accept;
    logic               push;

    assign rem_step   = mod_digit(rem_reg, shift_reg[frs_pkg::FRAME_W-1 -: frs_pkg::DIGIT_W]);
    assign last_digit = (digit_reg == frs_pkg::DIGIT_CNT_W'(frs_pkg::NUM_DIGITS - 1));
    assign job_valid  = busy_reg && last_digit;
    assign job.hdr    = hdr_reg;
    assign job.slot   = rem_step;
    assign push       = job_valid && job_ready;
    assign in_ready   = !busy_reg || push;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        digit_next = digit_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        hdr_next   = hdr_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            digit_next = '0;
            rem_next   = '0;
            shift_next = in_data.frame_number;
            hdr_next   = in_data;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !last_digit)
        begin
            digit_next = digit_reg + 1'b1;
            rem_next   = rem_step;
            shift_next = shift_reg << frs_pkg::DIGIT_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        hdr_reg   <= hdr_next;
    end

endmodule

`default_nettype wire

@@ src/frs_fifo.sv @@
// Short queue of classified headers between the front and back parts.
// Depends on frs_pkg.
`default_nettype none

module frs_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire frs_pkg::frs_job_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output frs_pkg::frs_job_t      pop_data
);

    frs_pkg::frs_job_t           entry_reg [frs_pkg::QDEPTH];
    logic [frs_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [frs_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [frs_pkg::QCNT_W-1:0]  count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != frs_pkg::QCNT_W'(frs_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == frs_pkg::QPTR_W'(frs_pkg::QDEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == frs_pkg::QPTR_W'(frs_pkg::QDEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/frs_back.sv @@
// Back part: slot table, release rules and the result register.
// Depends on frs_pkg.
`default_nettype none

module frs_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire frs_pkg::frs_job_t job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output frs_pkg::frs_out_t      out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_DEC
    } state_t;

    typedef struct packed {
        logic [frs_pkg::FRAME_W-1:0] frame;
        logic [frs_pkg::LINE_W-1:0]  lines;
        logic [frs_pkg::LINE_W-1:0]  height;
    } slot_entry_t;

    state_t                       state_reg,     state_next;
    frs_pkg::frs_job_t            job_reg,       job_next;
    logic [frs_pkg::SLOTS-1:0]    valid_reg,     valid_next;
    logic [frs_pkg::FRAME_W-1:0]  last_sent_reg, last_sent_next;
    logic                         opened_reg,    opened_next;
    logic                         overwrote_reg, overwrote_next;
    logic                         full_reg,      full_next;
    logic                         out_valid_reg, out_valid_next;
    frs_pkg::frs_out_t            out_reg,       out_next;

    // Slot memory: frame number, line count and height of each slot.
    slot_entry_t        slot_mem [frs_pkg::SLOTS];
    slot_entry_t        rd_a_reg;
    slot_entry_t        rd_b_reg;
    frs_pkg::slot_idx_t rd_a_addr;
    frs_pkg::slot_idx_t rd_b_addr;
    logic               mem_we;
    slot_entry_t        upd_entry;

    logic [frs_pkg::FRAME_W-1:0] n;
    logic [frs_pkg::FRAME_W-1:0] p1, p2, p3;
    frs_pkg::slot_idx_t          idx, i1, i2, i3;
    logic                        hold_cur;
    logic                        full_now;
    logic                        m1, m2, m3, v1, v2;
    logic                        full1, full2, full3;
    logic                        dec_go;
    logic                        emit, drop;
    frs_pkg::slot_idx_t          emit_slot, drop_slot;
    logic [frs_pkg::FRAME_W-1:0] emit_frame, drop_frame;

    assign n   = job_reg.hdr.frame_number;
    assign idx = job_reg.slot;
    assign p1  = n - frs_pkg::FRAME_W'(1);
    assign p2  = n - frs_pkg::FRAME_W'(2);
    assign p3  = n - frs_pkg::FRAME_W'(3);
    assign i1  = frs_pkg::slot_back(idx, 2'd1);
    assign i2  = frs_pkg::slot_back(idx, 2'd2);
    assign i3  = frs_pkg::slot_back(idx, 2'd3);

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Opening or counting in the current slot.
    assign hold_cur         = valid_reg[idx] && (rd_a_reg.frame == n);
    assign upd_entry.frame  = n;
    assign upd_entry.height = hold_cur ? rd_a_reg.height : job_reg.hdr.frame_height;
    assign upd_entry.lines  = (hold_cur ? rd_a_reg.lines : '0) + 1'b1;
    assign full_now         = (upd_entry.lines == upd_entry.height);
    assign mem_we           = (state_reg == ST_UPD);

    // Port A fetches the current slot, then the slot of n-2. Port B fetches the slot of n-1
    // when the current frame has just filled, otherwise the slot of n-3. While the decision
    // waits on the output, the registered fill flag keeps port B on the same slot.
    assign rd_a_addr = (state_reg == ST_IDLE) ? job.slot : i2;
    assign rd_b_addr = (((state_reg == ST_UPD) ? full_now : full_reg)) ? i1 : i3;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx] <= upd_entry;
        end
        rd_a_reg <= slot_mem[rd_a_addr];
        rd_b_reg <= slot_mem[rd_b_addr];
    end

    // Matches against the older frames. With three slots the slot of n-3 is the current one,
    // which now holds frame n and so never matches.
    assign v2    = valid_reg[i2];
    assign m2    = v2 && (rd_a_reg.frame == p2);
    assign full2 = (rd_a_reg.lines == rd_a_reg.height);
    assign v1    = valid_reg[i1];
    assign m1    = v1 && (rd_b_reg.frame == p1);
    assign full1 = (rd_b_reg.lines == rd_b_reg.height);
    assign m3    = valid_reg[i3] && (rd_b_reg.frame == p3) && (i3 != idx);
    assign full3 = full1;

    always_comb
    begin
        emit       = 1'b0;
        drop       = 1'b0;
        emit_slot  = '0;
        drop_slot  = '0;
        emit_frame = '0;
        drop_frame = '0;
        if (full_reg && (n >= frs_pkg::FRAME_W'(2)))
        begin
            if (!v2 || (m2 && !full2))
            begin
                if (m2)
                begin
                    drop       = 1'b1;
                    drop_slot  = i2;
                    drop_frame = p2;
                end
                if (m1 && full1)
                begin
                    emit       = 1'b1;
                    emit_slot  = i1;
                    emit_frame = p1;
                end
                else if (!v1)
                begin
                    emit       = 1'b1;
                    emit_slot  = idx;
                    emit_frame = n;
                end
            end
            else if (m2 && full2)
            begin
                emit       = 1'b1;
                emit_slot  = i2;
                emit_frame = p2;
            end
        end
        else if ((n >= frs_pkg::FRAME_W'(3)) && m3)
        begin
            if (full3)
            begin
                emit       = 1'b1;
                emit_slot  = i3;
                emit_frame = p3;
            end
            else
            begin
                drop       = 1'b1;
                drop_slot  = i3;
                drop_frame = p3;
            end
        end
    end

    assign dec_go = (state_reg == ST_DEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        valid_next     = valid_reg;
        last_sent_next = last_sent_reg;
        opened_next    = opened_reg;
        overwrote_next = overwrote_reg;
        full_next      = full_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                opened_next     = !hold_cur;
                overwrote_next  = !hold_cur && valid_reg[idx];
                full_next       = full_now;
                valid_next[idx] = 1'b1;
                state_next      = ST_DEC;
            end
            ST_DEC:
            begin
                if (dec_go)
                begin
                    if (drop)
                    begin
                        valid_next[drop_slot] = 1'b0;
                    end
                    if (emit)
                    begin
                        valid_next[emit_slot] = 1'b0;
                        last_sent_next        = emit_frame;
                    end
                    out_next.write_slot      = frs_pkg::SLOT_OUT_W'(idx);
                    out_next.write_line      = job_reg.hdr.line_index;
                    out_next.opened_slot     = opened_reg;
                    out_next.overwrote_frame = overwrote_reg;
                    out_next.emit_valid      = emit;
                    out_next.emit_slot       = frs_pkg::SLOT_OUT_W'(emit_slot);
                    out_next.emit_frame      = emit_frame;
                    out_next.emit_gap        = emit &&
                                               (emit_frame != last_sent_reg + 1'b1);
                    out_next.drop_valid      = drop;
                    out_next.drop_slot       = frs_pkg::SLOT_OUT_W'(drop_slot);
                    out_next.drop_frame      = drop_frame;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            valid_reg     <= '0;
            last_sent_reg <= '1;
            opened_reg    <= 1'b0;
            overwrote_reg <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            valid_reg     <= valid_next;
            last_sent_reg <= last_sent_next;
            opened_reg    <= opened_next;
            overwrote_reg <= overwrote_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ src/frame_reassembly_slot_tracker.sv @@
// Top level of the frame reassembly slot tracker: front, queue and back part joined.
// Depends on frs_pkg, frs_front, frs_fifo and frs_back.
//
//   Channel   Direction   Handshake            Word
//   in        input       in_valid/in_ready    frs_pkg::frs_in_t  (one line header)
//   out       output      out_valid/out_ready  frs_pkg::frs_out_t (one result per header)
//
// The front part reduces the 32-bit frame number modulo the slot count, one byte a cycle,
// and can take a new header as it hands the last one on. The back part handles each word
// as a slot read, a slot update and a release decision, and takes no new word until that
// decision is sent. Reset is asynchronous and active low; it empties every slot and
// needs no clearing pass. A stalled output holds its result while the queue and front
// part keep taking words until the queue is full.
`default_nettype none

module frame_reassembly_slot_tracker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire frs_pkg::frs_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output frs_pkg::frs_out_t     out_data
);

    // Classified headers travel from the front part into the queue ...
    logic              front_valid;
    logic              front_ready;
    frs_pkg::frs_job_t front_job;

    // ... and from the queue into the back part.
    logic              back_valid;
    logic              back_ready;
    frs_pkg::frs_job_t back_job;

    // The front part works out which slot the frame number maps to.
    frs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // A short queue lets the front part carry on while the back part waits on the output.
    frs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    // The back part owns the slot table, applies the release rules and holds the result.
    frs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ src/frs_checker.sv @@
// Port-level checks of the frame reassembly slot tracker, bound to its top level.
// Depends on frs_pkg and frame_reassembly_slot_tracker_assert.svh.
`default_nettype none

`include "frame_reassembly_slot_tracker_assert.svh"

module frs_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire frs_pkg::frs_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire frs_pkg::frs_out_t out_data
);

    `FRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    `FRS_ASSERT_NOW(a_emit_clean, out_valid && !out_data.emit_valid, out_data.emit_slot == '0 && out_data.emit_frame == '0 && !out_data.emit_gap, "emit fields set without a release")

    `FRS_ASSERT_NOW(a_drop_clean, out_valid && !out_data.drop_valid, out_data.drop_slot == '0 && out_data.drop_frame == '0, "drop fields set without a drop")

    `FRS_ASSERT_NOW(a_overwrite_opens, out_valid && out_data.overwrote_frame, out_data.opened_slot, "overwrite reported without opening a slot")

    `FRS_ASSERT_NOW(a_emit_drop_differ, out_valid && out_data.emit_valid && out_data.drop_valid, out_data.emit_frame != out_data.drop_frame, "same frame released and dropped")

endmodule

bind frame_reassembly_slot_tracker frs_checker u_frs_checker (.*);

`default_nettype wire
